@@ rtl/pearson_hash_bucket_index_defines.svh @@
// Assertion macros for the Pearson bucket index block.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef PEARSON_HASH_BUCKET_INDEX_DEFINES_SVH
`define PEARSON_HASH_BUCKET_INDEX_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define PBI_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("pbi check failed");

`define PBI_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pbi check failed");

`define PBI_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pbi check failed");

`else

`define PBI_ASSERT(label, clk, rst, prop)
`define PBI_ASSERT_IMP(label, clk, rst, ante, cons)
`define PBI_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/pbi_pkg.sv @@
// Package for the Pearson bucket index block: widths, reset bucket count, permutation table and FSM type.
// No dependencies.
package pbi_pkg;

  localparam int unsigned HASH_MAX_W = 64;
  localparam int unsigned BUCKET_W   = 32;
  localparam logic [BUCKET_W-1:0] BUCKET_COUNT_RST = 32'd1024;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_RUN,
    FE_HAND
  } fe_state_t;

  localparam logic [7:0] PERM_TABLE [0:255] = '{
    8'd238, 8'd93,  8'd78,  8'd153, 8'd181, 8'd80,  8'd29,  8'd94,
    8'd223, 8'd197, 8'd145, 8'd35,  8'd104, 8'd130, 8'd201, 8'd23,
    8'd137, 8'd198, 8'd162, 8'd51,  8'd72,  8'd1,   8'd248, 8'd117,
    8'd24,  8'd34,  8'd195, 8'd41,  8'd44,  8'd175, 8'd186, 8'd204,
    8'd245, 8'd48,  8'd3,   8'd55,  8'd27,  8'd52,  8'd193, 8'd194,
    8'd5,   8'd124, 8'd84,  8'd30,  8'd12,  8'd75,  8'd81,  8'd212,
    8'd89,  8'd95,  8'd22,  8'd180, 8'd146, 8'd65,  8'd165, 8'd31,
    8'd235, 8'd206, 8'd149, 8'd185, 8'd214, 8'd43,  8'd166, 8'd200,
    8'd140, 8'd102, 8'd188, 8'd161, 8'd11,  8'd125, 8'd196, 8'd230,
    8'd13,  8'd67,  8'd19,  8'd101, 8'd237, 8'd211, 8'd21,  8'd0,
    8'd189, 8'd218, 8'd239, 8'd105, 8'd232, 8'd9,   8'd252, 8'd203,
    8'd112, 8'd229, 8'd76,  8'd182, 8'd141, 8'd136, 8'd176, 8'd231,
    8'd40,  8'd199, 8'd143, 8'd250, 8'd191, 8'd90,  8'd45,  8'd33,
    8'd86,  8'd56,  8'd37,  8'd213, 8'd15,  8'd148, 8'd172, 8'd174,
    8'd100, 8'd126, 8'd6,   8'd225, 8'd253, 8'd10,  8'd132, 8'd74,
    8'd77,  8'd168, 8'd208, 8'd98,  8'd79,  8'd127, 8'd157, 8'd133,
    8'd113, 8'd99,  8'd219, 8'd4,   8'd114, 8'd190, 8'd207, 8'd163,
    8'd187, 8'd57,  8'd59,  8'd70,  8'd36,  8'd205, 8'd96,  8'd224,
    8'd183, 8'd63,  8'd103, 8'd173, 8'd177, 8'd73,  8'd17,  8'd66,
    8'd249, 8'd68,  8'd151, 8'd228, 8'd7,   8'd255, 8'd254, 8'd108,
    8'd247, 8'd62,  8'd192, 8'd159, 8'd47,  8'd85,  8'd20,  8'd16,
    8'd222, 8'd39,  8'd88,  8'd170, 8'd107, 8'd110, 8'd169, 8'd122,
    8'd109, 8'd115, 8'd18,  8'd210, 8'd241, 8'd236, 8'd202, 8'd178,
    8'd116, 8'd106, 8'd160, 8'd251, 8'd14,  8'd111, 8'd234, 8'd221,
    8'd38,  8'd242, 8'd42,  8'd244, 8'd217, 8'd156, 8'd129, 8'd53,
    8'd131, 8'd179, 8'd32,  8'd119, 8'd215, 8'd220, 8'd134, 8'd28,
    8'd138, 8'd152, 8'd142, 8'd26,  8'd167, 8'd155, 8'd227, 8'd209,
    8'd216, 8'd60,  8'd25,  8'd184, 8'd69,  8'd61,  8'd97,  8'd58,
    8'd120, 8'd71,  8'd64,  8'd226, 8'd240, 8'd91,  8'd2,   8'd50,
    8'd49,  8'd171, 8'd135, 8'd154, 8'd233, 8'd147, 8'd82,  8'd144,
    8'd123, 8'd83,  8'd243, 8'd246, 8'd128, 8'd164, 8'd54,  8'd139,
    8'd87,  8'd8,   8'd121, 8'd46,  8'd158, 8'd118, 8'd92,  8'd150
  };

endpackage

@@ rtl/pbi_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pbi_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/pbi_mod.sv @@
// Bit-serial restoring modulo unit with an output register for the bucket word.
// Depends on pbi_pkg and the assertion macros header.
`include "pearson_hash_bucket_index_defines.svh"

module pbi_mod #(
  parameter int HASH_W = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [HASH_W-1:0]             hash,
  input  logic [pbi_pkg::BUCKET_W-1:0]  divisor_in,
  output logic                          busy,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [pbi_pkg::BUCKET_W-1:0]  res_index
);
  import pbi_pkg::*;

  localparam int CNT_W = (HASH_W > 1) ? $clog2(HASH_W) : 1;

  logic [CNT_W-1:0]    cnt;
  logic [HASH_W-1:0]   dividend;
  logic [BUCKET_W-1:0] rem;
  logic [BUCKET_W-1:0] divisor;

  logic [BUCKET_W:0]   trial;
  logic [BUCKET_W:0]   diff;
  logic [BUCKET_W-1:0] rem_next;
  logic                last_step;
  logic                advance;

  always_comb begin
    trial     = {rem, dividend[HASH_W-1]};
    diff      = trial - {1'b0, divisor};
    rem_next  = (trial >= {1'b0, divisor}) ? diff[BUCKET_W-1:0] : trial[BUCKET_W-1:0];
    last_step = busy && (cnt == CNT_W'(HASH_W - 1));
    advance   = busy && (!last_step || !res_valid || res_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      res_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (advance && last_step) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        dividend <= hash;
        rem      <= '0;
        divisor  <= divisor_in;
      end else if (advance) begin
        rem      <= rem_next;
        dividend <= dividend << 1;
        cnt      <= cnt + 1'b1;
        if (last_step) begin
          busy      <= 1'b0;
          res_index <= (divisor == '0) ? '0 : rem_next;
        end
      end
    end
  end

  `PBI_ASSERT_IMP(a_start_when_free, clk, rst, start, !busy)
  `PBI_ASSERT_IMP(a_rem_in_range, clk, rst, busy && divisor != '0, rem < divisor)
  `PBI_ASSERT_NXT(a_done_sets_valid, clk, rst, last_step && advance, res_valid && !busy)

endmodule

@@ rtl/pearson_hash_bucket_index.sv @@
// Pearson bucket index: a key byte is taken in FE_IDLE, then FE_RUN does one lane RAM
// read-modify-write per cycle over the LANE_COUNT lanes; a last byte adds a handoff state
// (FE_HAND) that waits while the modulo is busy. The modulo works bit-serially over the
// 8*LANE_COUNT hash bits and overlaps the next key's bytes.
// Synchronous reset: no key in flight, bucket_count = 1024; lane RAM needs no clear.
`include "pearson_hash_bucket_index_defines.svh"

module pearson_hash_bucket_index #(
  parameter int LANE_COUNT = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [pbi_pkg::BUCKET_W-1:0]  cfg_wr_data,
  input  logic                          key_valid,
  output logic                          key_ready,
  input  logic [7:0]                    key_byte,
  input  logic                          last_byte,
  output logic                          bucket_valid,
  input  logic                          bucket_ready,
  output logic [pbi_pkg::BUCKET_W-1:0]  bucket_index
);
  import pbi_pkg::*;

  localparam int LANE_W = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;
  localparam int HASH_W = 8 * LANE_COUNT;

  fe_state_t           fe_state;
  fe_state_t           fe_state_next;
  logic [7:0]          key_q;
  logic                last_q;
  logic                first_q;
  logic                mid_key;
  logic [LANE_W-1:0]   lane_cnt;
  logic [HASH_W-1:0]   hash_q;
  logic [BUCKET_W-1:0] bucket_count;

  logic                key_acc;
  logic                lane_done;
  logic [7:0]          lane_new;
  logic                ram_wr_en;
  logic                ram_rd_en;
  logic [LANE_W-1:0]   ram_rd_addr;
  logic [7:0]          ram_rd_data;
  logic                mod_start;
  logic                mod_busy;

  pbi_ram #(
    .WIDTH (8),
    .DEPTH (LANE_COUNT),
    .ADDR_W(LANE_W)
  ) u_lane_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(lane_cnt),
    .wr_data(lane_new),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  pbi_mod #(
    .HASH_W(HASH_W)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .hash      (hash_q),
    .divisor_in(bucket_count),
    .busy      (mod_busy),
    .res_valid (bucket_valid),
    .res_ready (bucket_ready),
    .res_index (bucket_index)
  );

  always_comb begin
    fe_state_next = fe_state;
    key_ready     = 1'b0;
    ram_wr_en     = 1'b0;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = '0;
    mod_start     = 1'b0;
    lane_done     = (lane_cnt == LANE_W'(LANE_COUNT - 1));
    lane_new      = first_q ? PERM_TABLE[key_q + 8'(lane_cnt)]
                            : PERM_TABLE[ram_rd_data ^ key_q];
    case (fe_state)
      FE_IDLE: begin
        key_ready = 1'b1;
        ram_rd_en = key_valid;
        if (key_valid) begin
          fe_state_next = FE_RUN;
        end
      end
      FE_RUN: begin
        ram_wr_en   = 1'b1;
        ram_rd_en   = !lane_done;
        ram_rd_addr = lane_cnt + 1'b1;
        if (lane_done) begin
          fe_state_next = last_q ? FE_HAND : FE_IDLE;
        end
      end
      FE_HAND: begin
        mod_start = !mod_busy;
        if (!mod_busy) begin
          fe_state_next = FE_IDLE;
        end
      end
      default: begin
        fe_state_next = FE_IDLE;
      end
    endcase
    key_acc = key_valid && key_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fe_state     <= FE_IDLE;
      mid_key      <= 1'b0;
      lane_cnt     <= '0;
      bucket_count <= BUCKET_COUNT_RST;
    end else begin
      fe_state <= fe_state_next;
      if (cfg_wr_en) begin
        bucket_count <= cfg_wr_data;
      end
      if (key_acc) begin
        lane_cnt <= '0;
      end else if (fe_state == FE_RUN) begin
        if (lane_done) begin
          mid_key <= !last_q;
        end else begin
          lane_cnt <= lane_cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (key_acc) begin
      key_q   <= key_byte;
      last_q  <= last_byte;
      first_q <= !mid_key;
    end
    if (fe_state == FE_RUN) begin
      hash_q[{lane_cnt, 3'b000} +: 8] <= lane_new;
    end
  end

  `PBI_ASSERT_NXT(a_hand_starts, clk, rst, fe_state == FE_HAND && !mod_busy, mod_busy)
  `PBI_ASSERT_IMP(a_lane_bound, clk, rst, fe_state == FE_RUN,
                  lane_cnt <= LANE_W'(LANE_COUNT - 1))
  `PBI_ASSERT_NXT(a_last_clears_mid, clk, rst,
                  fe_state == FE_RUN && lane_done && last_q, !mid_key && fe_state == FE_HAND)

endmodule

@@ dv/pearson_bucket_checker.sv @@
// Checker for the Pearson bucket index block: watches the key, config and bucket channels,
// predicts each bucket word and compares it with what the block hands out.
// Depends on pbi_pkg (permutation table, widths, reset modulus).
module pearson_bucket_checker #(
  parameter int LANES = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [pbi_pkg::BUCKET_W-1:0] cfg_wr_data,
  input  logic                         key_valid,
  input  logic                         key_ready,
  input  logic [7:0]                   key_byte,
  input  logic                         last_byte,
  input  logic                         bucket_valid,
  input  logic                         bucket_ready,
  input  logic [pbi_pkg::BUCKET_W-1:0] bucket_index,
  output int unsigned                  error_count,
  output int unsigned                  open_count,
  output int unsigned                  checked_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import pbi_pkg::*;

  logic [7:0]            lanes [LANES];
  logic                  in_key;
  logic [BUCKET_W-1:0]   modulus;
  logic [BUCKET_W-1:0]   bucket_due [$];
  logic [HASH_MAX_W-1:0] packed_hash;
  logic [BUCKET_W-1:0]   want;

  initial begin
    error_count   = 0;
    open_count    = 0;
    checked_count = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANES; i++) lanes[i] = '0;
      in_key  = 1'b0;
      modulus = BUCKET_COUNT_RST;
      bucket_due.delete();
      error_count   <= 0;
      checked_count <= 0;
    end else begin
      if (cfg_wr_en) modulus = cfg_wr_data;
      if (key_valid && key_ready) begin
        for (int i = 0; i < LANES; i++) begin
          if (in_key) lanes[i] = PERM_TABLE[lanes[i] ^ key_byte];
          else        lanes[i] = PERM_TABLE[(int'(key_byte) + i) % 256];
        end
        in_key = !last_byte;
        if (last_byte) begin
          packed_hash = '0;
          for (int i = 0; i < LANES; i++) packed_hash[8*i +: 8] = lanes[i];
          // zero modulus is out of range: bucket is 0
          if (modulus == '0) packed_hash = '0;
          else               packed_hash = packed_hash % {32'd0, modulus};
          bucket_due.push_back(packed_hash[BUCKET_W-1:0]);
        end
      end
      if (bucket_valid && bucket_ready) begin
        if (bucket_due.size() == 0) begin
          $display("%0t: bucket_index expected none, got %0d", $time, bucket_index);
          error_count <= error_count + 1;
        end else begin
          want = bucket_due.pop_front();
          checked_count <= checked_count + 1;
          if (bucket_index !== want) begin
            $display("%0t: bucket_index expected %0d, got %0d", $time, want, bucket_index);
            error_count <= error_count + 1;
          end
        end
      end
    end
    open_count <= bucket_due.size();
  end

endmodule

@@ dv/tb_pearson_hash_bucket_index.sv @@
// Top of the Pearson bucket index testbench: clock, reset, key word stimulus, bucket
// back-pressure and modulus writes. Depends on pbi_pkg, the block and pearson_bucket_checker.
module tb_pearson_hash_bucket_index;
  timeunit 1ns;
  timeprecision 1ps;

  import pbi_pkg::*;

  localparam int LANE_COUNT    = 8;
  localparam int DRAIN_CYCLES  = 150;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_COUNT   = 10;
  localparam int PHASE_WORDS   = 150;
  localparam int FIXED_MODULI  = 7;

  // {last, byte}
  localparam logic [8:0] OPENING_WORDS [14] = '{
    9'h100, 9'h1FF, 9'h1FB,
    9'h000, 9'h100,
    9'h0FF, 9'h1FF,
    9'h055, 9'h0AA, 9'h00F, 9'h1F0,
    9'h080, 9'h001, 9'h17F
  };

  localparam logic [BUCKET_W-1:0] MODULI [FIXED_MODULI] = '{
    32'd0, 32'd1, 32'hFFFF_FFFF, 32'd3, 32'd256, 32'h8000_0001, 32'd1024
  };

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_wr_en;
  logic [BUCKET_W-1:0] cfg_wr_data;
  logic                key_valid;
  logic                key_ready;
  logic [7:0]          key_byte;
  logic                last_byte;
  logic                bucket_valid;
  logic                bucket_ready;
  logic [BUCKET_W-1:0] bucket_index;

  int unsigned error_count;
  int unsigned open_count;
  int unsigned checked_count;
  int unsigned words_sent;
  int unsigned moduli_used;
  int unsigned cycles;
  logic        steady;

  always #4 clk = ~clk;

  pearson_hash_bucket_index #(
    .LANE_COUNT(LANE_COUNT)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .key_valid   (key_valid),
    .key_ready   (key_ready),
    .key_byte    (key_byte),
    .last_byte   (last_byte),
    .bucket_valid(bucket_valid),
    .bucket_ready(bucket_ready),
    .bucket_index(bucket_index)
  );

  pearson_bucket_checker #(
    .LANES(LANE_COUNT)
  ) i_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .key_valid    (key_valid),
    .key_ready    (key_ready),
    .key_byte     (key_byte),
    .last_byte    (last_byte),
    .bucket_valid (bucket_valid),
    .bucket_ready (bucket_ready),
    .bucket_index (bucket_index),
    .error_count  (error_count),
    .open_count   (open_count),
    .checked_count(checked_count)
  );

  task automatic send_word(input logic [7:0] b, input logic fin);
    int gap;
    gap = steady ? 0 : $urandom_range(4);
    if (gap > 0) begin
      key_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    key_valid <= 1'b1;
    key_byte  <= b;
    last_byte <= fin;
    @(posedge clk);
    while (!key_ready) @(posedge clk);
    words_sent++;
  endtask

  // no key word in flight and every bucket word seen, then let the back end go quiet
  task automatic settle();
    key_valid <= 1'b0;
    do @(posedge clk); while (open_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_modulus(input logic [BUCKET_W-1:0] value);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    moduli_used++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_pearson_hash_bucket_index NOT OK");
      $finish;
    end
  end

  initial begin
    int gap;
    bucket_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(4);
      if (gap == 0) begin
        bucket_ready <= 1'b1;
        @(posedge clk);
        while (!bucket_valid) @(posedge clk);
      end else begin
        bucket_ready <= 1'b0;
        @(posedge clk);
        while (!bucket_valid) @(posedge clk);
        repeat (gap - 1) @(posedge clk);
        bucket_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    int r;
    int len;
    int sent_here;
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    key_valid   = 1'b0;
    key_byte    = '0;
    last_byte   = 1'b0;
    steady      = 1'b0;
    cycles      = 0;
    words_sent  = 0;
    moduli_used = 1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset modulus; byte extremes, lane index wrap, one-byte and longer keys
    foreach (OPENING_WORDS[j]) send_word(OPENING_WORDS[j][7:0], OPENING_WORDS[j][8]);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p < FIXED_MODULI) set_modulus(MODULI[p]);
      else                  set_modulus($urandom());
      sent_here = 0;
      while (sent_here < PHASE_WORDS) begin
        if ($urandom_range(7) == 0) steady = ~steady;
        r = $urandom_range(99);
        if (r < 10)      len = 1;
        else if (r < 85) len = $urandom_range(8, 2);
        else             len = $urandom_range(40, 9);
        for (int k = 0; k < len; k++) send_word(8'($urandom_range(255)), k == len - 1);
        sent_here += len;
      end
    end

    settle();
    $display("Sent %0d key words under %0d bucket counts (zero, one and all-ones included),",
             words_sent, moduli_used);
    $display("checked %0d bucket words with random gaps and stalls on both sides.",
             checked_count);
    if (error_count == 0 && open_count == 0) begin
      $display("tb_pearson_hash_bucket_index OK");
    end else begin
      $display("tb_pearson_hash_bucket_index NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/pbi_pkg.sv
rtl/pbi_ram.sv
rtl/pbi_mod.sv
rtl/pearson_hash_bucket_index.sv
dv/pearson_bucket_checker.sv
dv/tb_pearson_hash_bucket_index.sv
